// ----- rtl/slip_crc8_framer_macros.svh -----
// ----------------------------------------------------------------------------
// slip_crc8_framer assertion macros
// concurrent assertion forms used by slcf_back
// ----------------------------------------------------------------------------
`ifndef SLIP_CRC8_FRAMER_MACROS_SVH
`define SLIP_CRC8_FRAMER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SLCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("slcf assertion failed");

// next-cycle implication, disabled while reset is low
`define SLCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("slcf assertion failed");

`endif

// ----- rtl/slcf_pkg.sv -----
// ----------------------------------------------------------------------------
// slcf_pkg
// types, codes and the crc-8 fold shared by the framer modules
// ----------------------------------------------------------------------------
package slcf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned REG_W     = 16;

	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DATA    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_END_CODE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ESC_CODE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ESC_END     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ESC_ESC     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CAPACITY    = 3'd4;

	localparam logic [BYTE_W-1:0]  RST_END_CODE = 8'd192;
	localparam logic [BYTE_W-1:0]  RST_ESC_CODE = 8'd219;
	localparam logic [BYTE_W-1:0]  RST_ESC_END  = 8'd220;
	localparam logic [BYTE_W-1:0]  RST_ESC_ESC  = 8'd221;
	localparam logic [COUNT_W-1:0] RST_CAPACITY = 16'hFFFF;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              no_room;
		logic              last;
	} res_t;

	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	localparam res_t RES_NO_ROOM = '{out_byte: '0, byte_valid: 1'b0, no_room: 1'b1, last: 1'b1};

	function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			if ((c & CRC_TOP) != '0) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic res_t mk_byte(input logic [BYTE_W-1:0] b, input logic fin);
		res_t r;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		r.no_room    = 1'b0;
		r.last       = fin;
		return r;
	endfunction

endpackage

// ----- rtl/slcf_front.sv -----
// ----------------------------------------------------------------------------
// slcf_front
// takes commands, holds registers, count and crc, builds result entries
// ----------------------------------------------------------------------------
module slcf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slcf_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [slcf_pkg::REG_W-1:0]      cfg_wdata,
	input  logic                            in_fire,
	input  logic [slcf_pkg::CMD_W-1:0]      cmd,
	input  logic [slcf_pkg::BYTE_W-1:0]     data_byte,
	output logic                            push,
	output slcf_pkg::entry_t                entry
);
	import slcf_pkg::*;

	logic [BYTE_W-1:0]  end_code_q, esc_code_q, esc_end_q, esc_esc_q;
	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0]  crc_q, crc_d;
	logic [COUNT_W:0]   cnt_ext, cap_ext;
	logic               room1, room2, is_end, is_esc;
	logic [BYTE_W-1:0]  sub_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q <= RST_END_CODE;
			esc_code_q <= RST_ESC_CODE;
			esc_end_q  <= RST_ESC_END;
			esc_esc_q  <= RST_ESC_ESC;
			cap_q      <= RST_CAPACITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_END_CODE: end_code_q <= cfg_wdata[BYTE_W-1:0];
				REG_ESC_CODE: esc_code_q <= cfg_wdata[BYTE_W-1:0];
				REG_ESC_END:  esc_end_q  <= cfg_wdata[BYTE_W-1:0];
				REG_ESC_ESC:  esc_esc_q  <= cfg_wdata[BYTE_W-1:0];
				REG_CAPACITY: cap_q      <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cnt_ext  = {1'b0, count_q};
	assign cap_ext  = {1'b0, cap_q};
	assign room1    = (cnt_ext + (COUNT_W+1)'(1)) <= cap_ext;
	assign room2    = (cnt_ext + (COUNT_W+1)'(2)) <= cap_ext;
	assign is_end   = data_byte == end_code_q;
	assign is_esc   = data_byte == esc_code_q;
	assign sub_byte = is_end ? esc_end_q : esc_esc_q;

	always_comb begin
		count_d  = count_q;
		crc_d    = crc_q;
		push     = 1'b0;
		entry.two = 1'b0;
		entry.r0  = RES_NO_ROOM;
		entry.r1  = RES_NO_ROOM;
		unique case (cmd)
			CMD_RESTART: begin
				count_d = '0;
				crc_d   = CRC_INIT;
			end
			CMD_START: begin
				push = 1'b1;
				if (room1) begin
					entry.r0 = mk_byte(end_code_q, 1'b1);
					count_d  = count_q + COUNT_W'(1);
				end
			end
			CMD_DATA: begin
				push = 1'b1;
				if (is_end || is_esc) begin
					if (room2) begin
						entry.two = 1'b1;
						entry.r0  = mk_byte(esc_code_q, 1'b0);
						entry.r1  = mk_byte(sub_byte, 1'b1);
						count_d   = count_q + COUNT_W'(2);
						crc_d     = crc_fold(crc_fold(crc_q, esc_code_q), sub_byte);
					end
				end else if (room1) begin
					entry.r0 = mk_byte(data_byte, 1'b1);
					count_d  = count_q + COUNT_W'(1);
					crc_d    = crc_fold(crc_q, data_byte);
				end
			end
			CMD_FINISH: begin
				push  = 1'b1;
				crc_d = CRC_INIT;
				if (room1) begin
					entry.two = 1'b1;
					entry.r0  = mk_byte(crc_q, 1'b0);
					if (room2) begin
						entry.r1 = mk_byte(end_code_q, 1'b1);
						count_d  = count_q + COUNT_W'(2);
					end else begin
						count_d  = count_q + COUNT_W'(1);
					end
				end
			end
			default: ;
		endcase
		push = push & in_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
		end else if (in_fire) begin
			count_q <= count_d;
			crc_q   <= crc_d;
		end
	end

endmodule

// ----- rtl/slcf_queue.sv -----
// ----------------------------------------------------------------------------
// slcf_queue
// short register queue of result entries between front and back
// ----------------------------------------------------------------------------
module slcf_queue #(
	parameter int unsigned DEPTH = slcf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  slcf_pkg::entry_t push_entry,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output slcf_pkg::entry_t head
);
	import slcf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign not_full  = count_q != CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/slcf_back.sv -----
// ----------------------------------------------------------------------------
// slcf_back
// unpacks queue entries into result beats, one beat per cycle while out_ready is high
// ----------------------------------------------------------------------------
module slcf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  slcf_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output slcf_pkg::res_t   out_res
);
	import slcf_pkg::*;

	`include "slip_crc8_framer_macros.svh"

	logic out_valid_q, pend_valid_q, fire, free;
	res_t out_res_q, pend_res_q;

	assign fire      = out_valid_q && out_ready;
	assign free      = !out_valid_q || fire;
	assign pop       = free && !pend_valid_q && head_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk) begin
		if (free && pend_valid_q) begin
			out_res_q <= pend_res_q;
		end else if (pop) begin
			out_res_q  <= head.r0;
			pend_res_q <= head.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= head_valid;
				pend_valid_q <= head_valid && head.two;
			end
		end
	end

	`SLCF_ASSERT_IMPL(a_pend_has_out, clk, arst_n, pend_valid_q, out_valid_q)
	`SLCF_ASSERT_NEXT(a_second_is_last, clk, arst_n, pend_valid_q && fire,
		out_valid_q && out_res_q.last)
	`SLCF_ASSERT_IMPL(a_no_room_shape, clk, arst_n, out_valid_q && out_res_q.no_room,
		!out_res_q.byte_valid && out_res_q.last && out_res_q.out_byte == '0)

endmodule

// ----- rtl/slip_crc8_framer.sv -----
// ----------------------------------------------------------------------------
// slip_crc8_framer
// slip byte-stuffing frame encoder with running crc-8 and capacity limit
// ----------------------------------------------------------------------------
// channel  direction  tdata           tuser                   tlast
// s_axis   in         data_byte[7:0]  cmd[1:0]                -
// m_axis   out        out_byte[7:0]   no_room, byte_valid     last
// cfg      in         cfg_wdata       -                       -
//
// a command is taken every cycle while the queue has room; restart gives no beat
// escape pairs and finish with room give two beats
// the first beat of a taken command passes through a queue slot, then the output register
// output stalls fill the queue of QUEUE_DEPTH entries, then s_axis_tready falls
// reset clears count, queue and output and sets crc to CRC_INIT; registers take their default codes
// ----------------------------------------------------------------------------
module slip_crc8_framer #(
	parameter int unsigned QUEUE_DEPTH = slcf_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slcf_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [slcf_pkg::REG_W-1:0]      cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // data_byte
	input  logic [1:0]                      s_axis_tuser,  // cmd
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // out_byte
	output logic [1:0]                      m_axis_tuser,  // no_room, byte_valid
	output logic                            m_axis_tlast
);
	import slcf_pkg::*;

	logic   in_fire, push, q_not_full, q_not_empty, pop;
	entry_t entry, head;
	res_t   out_res;

	assign s_axis_tready = q_not_full;
	assign in_fire       = s_axis_tvalid && q_not_full;

	slcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.cmd       (s_axis_tuser),
		.data_byte (s_axis_tdata),
		.push      (push),
		.entry     (entry)
	);

	slcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.not_full   (q_not_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	slcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = out_res.out_byte;
	assign m_axis_tuser = {out_res.no_room, out_res.byte_valid};
	assign m_axis_tlast = out_res.last;

endmodule
